@@ design/sres_pkg.sv @@
// ----------------------------------------------------------------------------
// Resequencer package
// Shared types and codes of the sequence-number resequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sres_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_SEQ    = 2'd0;
	localparam logic [1:0] KIND_UNSEQ  = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	// One pending entry as held by a store cell.
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] tag;
		logic        end_f;
		logic        stream;
	} cell_data_t;

	// Commands broadcast to every store cell.
	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} cell_ctrl_t;

	// One result item.
	typedef struct packed {
		logic               has_item;
		logic [15:0]        out_tag;
		logic               out_end;
		logic               out_stream;
		logic               cancel_frame;
		logic signed [31:0] frame_request;
		logic               overflow;
		logic               closed;
		logic               last;
	} result_t;

	// Control states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

endpackage

`default_nettype wire

@@ design/sequence_number_resequencer.sv @@
// Sequence-number resequencer. Sequenced items leave in number order: an item
// whose number is at most the last released number plus one leaves at once,
// then held items are drained from the head of a sorted row of store cells for
// as long as their numbers stay in sequence. Later items are inserted into the
// row, which shifts to make room; when the row is full the item is dropped and
// overflow is flagged. Every input transfer yields one or more result
// transfers, the final one marked by m_tlast. An item is accepted while idle,
// then evaluated, then each drained entry yields one result in the drain
// state; the control sequence accepts only while idle. A result that waits on
// m_tready holds the block in place. The store needs no clearing pass after
// reset.
// ----------------------------------------------------------------------------
// Sequence-number resequencer
// Releases tagged items in sequence order through a sorted chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_number_resequencer
	import sres_pkg::*;
#(
	parameter int PENDING_DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// Configuration: request number.
	input  wire                cfg_we,
	input  wire signed [31:0]  cfg_wdata,
	// Input stream.
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire  [47:0]        s_tdata,   // sequence_req[31:0], payload_tag[47:32]
	input  wire  [2:0]         s_tuser,   // kind[1:0], stream_flag[2]
	input  wire                s_tlast,   // end_flag
	// Result stream.
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [55:0]        m_tdata,   // out_tag[15:0], out_end[16], out_stream[17],
	                                      // frame_request[49:18], overflow[50],
	                                      // closed[51], zero[55:52]
	output logic [1:0]         m_tuser,   // has_item[0], cancel_frame[1]
	output logic               m_tlast    // last
);

	state_t             state_q;
	logic signed [31:0] req_q;
	logic [31:0]        last_rel_q;
	logic               closed_q;
	logic               close_pend_q;

	logic [1:0]         in_kind_q;
	logic [31:0]        in_seq_q;
	logic [15:0]        in_tag_q;
	logic               in_end_q;
	logic               in_stream_q;

	logic               m_valid_q;
	result_t            res_q;

	cell_ctrl_t         ctrl;
	cell_data_t         ins_data;
	cell_data_t         head_prev;
	cell_data_t         cdat [PENDING_DEPTH];
	logic [PENDING_DEPTH-1:0] cval;
	logic [PENDING_DEPTH-1:0] cgt;
	logic [PENDING_DEPTH-1:0] clink;
	logic [PENDING_DEPTH-1:0] ok;
	logic [PENDING_DEPTH-1:0] run;
	logic [PENDING_DEPTH-1:0] cend;
	logic               fin_drain;

	logic               out_free;
	logic [31:0]        rel_limit;
	result_t            eval_res;
	logic               eval_insert;
	logic               eval_close;
	logic               eval_drain;
	logic               eval_rel;
	result_t            drain_res;
	logic               drain_last;

	assign out_free = !m_valid_q || m_tready;

	// The head cell compares against the arriving number while evaluating and
	// against the last released number while draining.
	always_comb begin
		head_prev        = '0;
		head_prev.seq    = (state_q == ST_EVAL) ? in_seq_q : last_rel_q;
		ins_data.seq     = in_seq_q;
		ins_data.tag     = in_tag_q;
		ins_data.end_f   = in_end_q;
		ins_data.stream  = in_stream_q;
	end

	// Row of store cells, head at index zero.
	for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
		cell_data_t p_dat;
		logic       p_val;
		logic       p_gt;
		cell_data_t n_dat;
		logic       n_val;

		if (i == 0) begin : g_head
			assign p_dat = head_prev;
			assign p_val = 1'b1;
			assign p_gt  = 1'b0;
		end else begin : g_body
			assign p_dat = cdat[i-1];
			assign p_val = cval[i-1];
			assign p_gt  = cgt[i-1];
		end

		if (i == PENDING_DEPTH - 1) begin : g_tail
			assign n_dat = '0;
			assign n_val = 1'b0;
		end else begin : g_mid
			assign n_dat = cdat[i+1];
			assign n_val = cval[i+1];
		end

		sres_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.ins_data   (ins_data),
			.prev_data  (p_dat),
			.prev_valid (p_val),
			.prev_gt    (p_gt),
			.next_data  (n_dat),
			.next_valid (n_val),
			.cur_data   (cdat[i]),
			.cur_valid  (cval[i]),
			.cur_gt     (cgt[i]),
			.cur_link   (clink[i])
		);

		assign cend[i] = cdat[i].end_f;
	end

	// Run of entries that drain after a release, and whether one ends the stream.
	always_comb begin
		ok     = cval & clink;
		run[0] = ok[0];
		for (int i = 1; i < PENDING_DEPTH; i++) begin
			run[i] = run[i-1] & ok[i];
		end
		fin_drain = |(run & cend);
	end

	// Decision for the item held in the input register.
	always_comb begin
		rel_limit   = last_rel_q + 32'd1;
		eval_res    = '0;
		eval_res.last = 1'b1;
		eval_insert = 1'b0;
		eval_close  = 1'b0;
		eval_drain  = 1'b0;
		eval_rel    = 1'b0;
		if (!closed_q) begin
			case (in_kind_q)
				KIND_CANCEL: begin
					eval_res.has_item      = 1'b1;
					eval_res.out_end       = 1'b1;
					eval_res.out_stream    = 1'b1;
					eval_res.cancel_frame  = 1'b1;
					eval_res.frame_request = req_q;
					eval_close             = 1'b1;
				end
				KIND_UNSEQ: begin
					eval_res.has_item      = 1'b1;
					eval_res.out_tag       = in_tag_q;
					eval_res.out_end       = in_end_q;
					eval_res.out_stream    = in_stream_q;
					eval_res.frame_request = req_q;
					eval_close             = in_end_q || !in_stream_q;
				end
				KIND_SEQ: begin
					if (in_seq_q <= rel_limit) begin
						eval_rel               = 1'b1;
						eval_drain             = run[0];
						eval_res.has_item      = 1'b1;
						eval_res.out_tag       = in_tag_q;
						eval_res.out_end       = in_end_q;
						eval_res.out_stream    = in_stream_q;
						eval_res.frame_request = req_q;
						eval_res.last          = !run[0];
						eval_close             = in_end_q || fin_drain || !in_stream_q;
					end else if (!cval[PENDING_DEPTH-1]) begin
						eval_insert = 1'b1;
						eval_close  = !in_stream_q;
					end else begin
						eval_res.overflow = 1'b1;
						eval_close        = !in_stream_q;
					end
				end
				default: begin
				end
			endcase
		end
		eval_res.closed = closed_q || eval_close;
	end

	// Result for the head entry while draining.
	always_comb begin
		drain_last               = !ok[1];
		drain_res                = '0;
		drain_res.has_item       = 1'b1;
		drain_res.out_tag        = cdat[0].tag;
		drain_res.out_end        = cdat[0].end_f;
		drain_res.out_stream     = cdat[0].stream;
		drain_res.frame_request  = req_q;
		drain_res.closed         = closed_q;
		drain_res.last           = drain_last;
	end

	// Commands to the cell row.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_EVAL: begin
				if (out_free) begin
					ctrl.insert = eval_insert;
					ctrl.clear  = eval_close && !eval_drain;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					ctrl.pop   = 1'b1;
					ctrl.clear = drain_last && close_pend_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state, last released number and the closed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_rel_q   <= '0;
			closed_q     <= 1'b0;
			close_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						if (eval_rel) begin
							last_rel_q <= in_seq_q;
						end
						if (eval_close) begin
							closed_q <= 1'b1;
						end
						close_pend_q <= eval_close;
						state_q      <= eval_drain ? ST_DRAIN : ST_IDLE;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						last_rel_q <= cdat[0].seq;
						if (drain_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input register, loaded on each input transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_kind_q   <= s_tuser[1:0];
			in_stream_q <= s_tuser[2];
			in_seq_q    <= s_tdata[31:0];
			in_tag_q    <= s_tdata[47:32];
			in_end_q    <= s_tlast;
		end
	end

	// Request number register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else if (cfg_we) begin
			req_q <= cfg_wdata;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_EVAL || state_q == ST_DRAIN)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register contents.
	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EVAL) begin
			res_q <= eval_res;
		end else if (out_free && state_q == ST_DRAIN) begin
			res_q <= drain_res;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tlast  = res_q.last;
	assign m_tuser  = {res_q.cancel_frame, res_q.has_item};
	assign m_tdata  = {4'b0000, res_q.closed, res_q.overflow, res_q.frame_request,
	                   res_q.out_stream, res_q.out_end, res_q.out_tag};

`ifndef SYNTHESIS
	// Occupied cells always form one block at the head of the row.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cval} + {{PENDING_DEPTH{1'b0}}, 1'b1}))
		else $error("store cells are not packed at the head");

	// Draining only ever reads an occupied head cell.
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> cval[0])
		else $error("drain with empty head cell");

	// An insert never happens into a full row.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |-> !cval[PENDING_DEPTH-1])
		else $error("insert into full store");

	// Once closed and back at rest, the store is empty.
	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && closed_q) |-> (cval == '0))
		else $error("closed block still holds pending entries");
`endif

endmodule

`default_nettype wire

@@ design/sres_cell.sv @@
// ----------------------------------------------------------------------------
// Resequencer store cell
// One entry of the sorted pending store; shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sres_cell
	import sres_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  cell_ctrl_t  ctrl,
	input  cell_data_t  ins_data,
	input  cell_data_t  prev_data,
	input  wire         prev_valid,
	input  wire         prev_gt,
	input  cell_data_t  next_data,
	input  wire         next_valid,
	output cell_data_t  cur_data,
	output logic        cur_valid,
	output logic        cur_gt,
	output logic        cur_link
);

	cell_data_t  data_q;
	logic        valid_q;
	logic [31:0] limit;
	logic        place;

	// Compare against the new item and against the neighbor nearer the head.
	always_comb begin
		limit    = prev_data.seq + 32'd1;
		cur_gt   = valid_q && (data_q.seq > ins_data.seq);
		cur_link = (data_q.seq <= limit);
		place    = prev_valid && !prev_gt && (!valid_q || cur_gt);
	end

	// Valid bit: cleared on close, shifted on pop and insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && (prev_gt || place)) begin
			valid_q <= 1'b1;
		end
	end

	// Entry contents follow the same moves as the valid bit.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			data_q <= next_data;
		end else if (ctrl.insert && prev_gt) begin
			data_q <= prev_data;
		end else if (ctrl.insert && place) begin
			data_q <= ins_data;
		end
	end

	assign cur_data  = data_q;
	assign cur_valid = valid_q;

endmodule

`default_nettype wire
